/* src/pbl_pkg.sv */
package pbl_pkg;

    // Palette geometry, fixed by the field widths
    localparam int PAL_DEPTH  = 16;
    localparam int PAL_IDX_W  = 4;
    localparam int CHAN_W     = 8;

    // Queue depths (default values for the top-level parameters)
    localparam int DEF_QUEUE_DEPTH = 4;
    localparam int DEF_OUT_DEPTH   = 4;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic REG_BRIGHTNESS = 1'b0;
    localparam logic REG_BLEND      = 1'b1;

    localparam logic [CHAN_W-1:0] BRIGHTNESS_RESET = 8'hFF;
    localparam logic              BLEND_RESET      = 1'b1;
    localparam logic [CHAN_W-1:0] FULL_SCALE       = 8'hFF;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_WRITE  = 1'b1
    } t_op;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    // Classified lookup, handed from the front to the back
    typedef struct packed {
        t_rgb                 base;
        t_rgb                 next;
        logic [PAL_IDX_W-1:0] frac;
        logic                 blend;
    } t_mid_item;

endpackage

/* src/pbl_queue.sv */
module pbl_queue #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_push_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_head,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [IW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [IW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign do_push = i_push && ((r_count != CW'(DEPTH)) || do_pop);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == IW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == IW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

/* src/pbl_front.sv */
module pbl_front #(
    parameter int QUEUE_DEPTH = pbl_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    output logic                             o_full,
    input  logic                             i_operation,
    input  logic [7:0]                       i_color_index,
    input  logic [pbl_pkg::PAL_IDX_W-1:0]    i_entry_slot,
    input  logic [pbl_pkg::CHAN_W-1:0]       i_entry_red,
    input  logic [pbl_pkg::CHAN_W-1:0]       i_entry_green,
    input  logic [pbl_pkg::CHAN_W-1:0]       i_entry_blue,
    input  logic                             i_blend_mode,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] i_mid_count,
    output logic                             o_mid_push,
    output pbl_pkg::t_mid_item               o_mid_item
);
    import pbl_pkg::*;

    localparam int SW = $clog2(QUEUE_DEPTH + 2);

    t_rgb                 r_pal_mem [PAL_DEPTH];
    logic                 r_f1_valid;
    t_rgb                 r_base;
    t_rgb                 r_next;
    logic [PAL_IDX_W-1:0] r_frac;
    logic                 r_blend;

    logic                 accept;
    logic                 is_write;
    logic [PAL_IDX_W-1:0] hi_idx;
    logic [PAL_IDX_W-1:0] nxt_idx;
    logic [PAL_IDX_W-1:0] lo_frac;
    logic [SW-1:0]        pending;

    // Reserve a queue slot for the lookup held in the read stage
    assign pending = SW'(i_mid_count) + SW'(r_f1_valid);
    assign o_full  = (pending >= SW'(QUEUE_DEPTH));
    assign accept  = i_push && !o_full;
    assign is_write = (t_op'(i_operation) == OP_WRITE);

    assign hi_idx  = i_color_index[7:4];
    assign lo_frac = i_color_index[3:0];
    assign nxt_idx = hi_idx + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else begin
            r_f1_valid <= accept && !is_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_write) begin
            r_pal_mem[i_entry_slot] <= '{red: i_entry_red, green: i_entry_green,
                                         blue: i_entry_blue};
        end
        if (accept && !is_write) begin
            r_base  <= r_pal_mem[hi_idx];
            r_next  <= r_pal_mem[nxt_idx];
            r_frac  <= lo_frac;
            r_blend <= (lo_frac != '0) && i_blend_mode;
        end
    end

    assign o_mid_push = r_f1_valid;
    assign o_mid_item = '{base: r_base, next: r_next, frac: r_frac, blend: r_blend};

endmodule

/* src/pbl_back.sv */
module pbl_back #(
    parameter int QUEUE_DEPTH = pbl_pkg::DEF_QUEUE_DEPTH,
    parameter int OUT_DEPTH   = pbl_pkg::DEF_OUT_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pbl_pkg::t_mid_item               i_mid_item,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] i_mid_count,
    output logic                             o_mid_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]   i_out_count,
    output logic                             o_out_push,
    output pbl_pkg::t_rgb                    o_out_data,
    input  logic [pbl_pkg::CHAN_W-1:0]       i_brightness
);
    import pbl_pkg::*;

    localparam int OW = $clog2(OUT_DEPTH + 2);

    logic          r_b1_valid;
    t_rgb          r_mixed;
    t_rgb          mixed;
    logic [7:0]    w_next;
    logic [OW-1:0] out_pending;

    function automatic logic [CHAN_W-1:0] blend_chan(
        input logic [CHAN_W-1:0] c_base,
        input logic [CHAN_W-1:0] c_next,
        input logic [CHAN_W-1:0] w2
    );
        logic [CHAN_W-1:0]   w1;
        logic [2*CHAN_W-1:0] p1;
        logic [2*CHAN_W-1:0] p2;
        logic [CHAN_W:0]     s;
        w1 = FULL_SCALE - w2;
        p1 = c_base * w1;
        p2 = c_next * w2;
        s  = {1'b0, p1[2*CHAN_W-1:CHAN_W]} + {1'b0, p2[2*CHAN_W-1:CHAN_W]};
        return s[CHAN_W-1:0];
    endfunction

    // Brightness b scales by (b+1)/256: full scale passes, zero blacks out
    function automatic logic [CHAN_W-1:0] dim_chan(
        input logic [CHAN_W-1:0] c,
        input logic [CHAN_W-1:0] bright
    );
        logic [CHAN_W:0]     f;
        logic [2*CHAN_W:0]   p;
        f = {1'b0, bright} + 1'b1;
        p = (2*CHAN_W+1)'(c) * (2*CHAN_W+1)'(f);
        return p[2*CHAN_W-1:CHAN_W];
    endfunction

    // Take a lookup only when the result queue has room for it
    assign out_pending = OW'(i_out_count) + OW'(r_b1_valid);
    assign o_mid_pop   = (i_mid_count != '0) && (out_pending < OW'(OUT_DEPTH));

    assign w_next = {i_mid_item.frac, 4'b0000};

    always_comb begin
        if (i_mid_item.blend) begin
            mixed.red   = blend_chan(i_mid_item.base.red,   i_mid_item.next.red,   w_next);
            mixed.green = blend_chan(i_mid_item.base.green, i_mid_item.next.green, w_next);
            mixed.blue  = blend_chan(i_mid_item.base.blue,  i_mid_item.next.blue,  w_next);
        end else begin
            mixed = i_mid_item.base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
        end else begin
            r_b1_valid <= o_mid_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_mid_pop) begin
            r_mixed <= mixed;
        end
    end

    assign o_out_push       = r_b1_valid;
    assign o_out_data.red   = dim_chan(r_mixed.red,   i_brightness);
    assign o_out_data.green = dim_chan(r_mixed.green, i_brightness);
    assign o_out_data.blue  = dim_chan(r_mixed.blue,  i_brightness);

endmodule

/* src/palette_blend_lookup.sv */
// Path: a lookup accepted on the item side passes, in order, the palette read,
//   lookup queue, blend stage and result queue before it shows on the result ports.
// Throughput: one item per cycle while o_full is low; a write yields no result.
//   The rate is set by the single-write, dual-read palette memory and the queue credits.
// Reset: synchronous, active low; empties both queues, clears stage valids,
//   sets brightness to 255 and blending on. Palette contents are not cleared.
module palette_blend_lookup #(
    parameter int QUEUE_DEPTH = pbl_pkg::DEF_QUEUE_DEPTH,
    parameter int OUT_DEPTH   = pbl_pkg::DEF_OUT_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // item side
    input  logic                             i_push,
    output logic                             o_full,
    input  logic                             i_operation,
    input  logic [7:0]                       i_color_index,
    input  logic [pbl_pkg::PAL_IDX_W-1:0]    i_entry_slot,
    input  logic [pbl_pkg::CHAN_W-1:0]       i_entry_red,
    input  logic [pbl_pkg::CHAN_W-1:0]       i_entry_green,
    input  logic [pbl_pkg::CHAN_W-1:0]       i_entry_blue,
    // result side
    output logic                             o_empty,
    input  logic                             i_pop,
    output logic [pbl_pkg::CHAN_W-1:0]       o_out_red,
    output logic [pbl_pkg::CHAN_W-1:0]       o_out_green,
    output logic [pbl_pkg::CHAN_W-1:0]       o_out_blue,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pbl_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [pbl_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [pbl_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import pbl_pkg::*;

    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int OCW = $clog2(OUT_DEPTH + 1);

    logic [CHAN_W-1:0] r_brightness;
    logic              r_blend_mode;
    logic              cfg_write;
    logic              reg_sel;

    logic              mid_push;
    logic              mid_pop;
    t_mid_item         mid_in;
    t_mid_item         mid_head;
    logic [QCW-1:0]    mid_count;

    logic              out_push;
    logic              out_pop;
    t_rgb              out_in;
    t_rgb              out_head;
    logic [OCW-1:0]    out_count;

    // Configuration registers: one access-phase transfer writes, reads decode the address
    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= BRIGHTNESS_RESET;
            r_blend_mode <= BLEND_RESET;
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_BRIGHTNESS: r_brightness <= pwdata[CHAN_W-1:0];
                REG_BLEND:      r_blend_mode <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_BRIGHTNESS: prdata = {{(CFG_DATA_W-CHAN_W){1'b0}}, r_brightness};
            REG_BLEND:      prdata = {{(CFG_DATA_W-1){1'b0}}, r_blend_mode};
            default:        prdata = '0;
        endcase
    end

    // Front: accept items, update the palette, read the entry pair, classify
    pbl_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_operation   (i_operation),
        .i_color_index (i_color_index),
        .i_entry_slot  (i_entry_slot),
        .i_entry_red   (i_entry_red),
        .i_entry_green (i_entry_green),
        .i_entry_blue  (i_entry_blue),
        .i_blend_mode  (r_blend_mode),
        .i_mid_count   (mid_count),
        .o_mid_push    (mid_push),
        .o_mid_item    (mid_in)
    );

    // Lookup queue between front and back
    pbl_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(t_mid_item))
    ) u_mid_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (mid_push),
        .i_push_data (mid_in),
        .i_pop       (mid_pop),
        .o_head      (mid_head),
        .o_count     (mid_count)
    );

    // Back: blend, then brightness scale into the result queue
    pbl_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .OUT_DEPTH   (OUT_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mid_item   (mid_head),
        .i_mid_count  (mid_count),
        .o_mid_pop    (mid_pop),
        .i_out_count  (out_count),
        .o_out_push   (out_push),
        .o_out_data   (out_in),
        .i_brightness (r_brightness)
    );

    // Result queue: its head drives the result ports
    assign out_pop = i_pop && !o_empty;

    pbl_queue #(
        .DEPTH (OUT_DEPTH),
        .WIDTH ($bits(t_rgb))
    ) u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (out_push),
        .i_push_data (out_in),
        .i_pop       (out_pop),
        .o_head      (out_head),
        .o_count     (out_count)
    );

    assign o_empty     = (out_count == '0);
    assign o_out_red   = out_head.red;
    assign o_out_green = out_head.green;
    assign o_out_blue  = out_head.blue;

endmodule

/* src/pbl_checker.sv */
module pbl_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_full,
    input logic                           o_empty,
    input logic                           i_pop,
    input logic [pbl_pkg::CHAN_W-1:0]     o_out_red,
    input logic [pbl_pkg::CHAN_W-1:0]     o_out_green,
    input logic [pbl_pkg::CHAN_W-1:0]     o_out_blue,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [pbl_pkg::CFG_ADDR_W-1:0] paddr,
    input logic [pbl_pkg::CFG_DATA_W-1:0] pwdata,
    input logic [pbl_pkg::CFG_DATA_W-1:0] prdata,
    input logic                           pready
);
    import pbl_pkg::*;

    logic cfg_write;
    assign cfg_write = psel && penable && pwrite && pready;

    // Reset leaves both sides idle
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("queues not idle after reset");

    // A waiting result holds until its transfer
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=>
            ($stable(o_out_red) && $stable(o_out_green) && $stable(o_out_blue)))
        else $error("waiting result changed");

    // Brightness reads back what was written
    a_bright_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_write && paddr[2] == REG_BRIGHTNESS) |=>
            (paddr[2] != REG_BRIGHTNESS || prdata == {24'b0, $past(pwdata[7:0])}))
        else $error("brightness readback mismatch");

    // Blend mode reads back what was written
    a_blend_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_write && paddr[2] == REG_BLEND) |=>
            (paddr[2] != REG_BLEND || prdata == {31'b0, $past(pwdata[0])}))
        else $error("blend mode readback mismatch");

endmodule

bind palette_blend_lookup pbl_checker u_pbl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_full      (o_full),
    .o_empty     (o_empty),
    .i_pop       (i_pop),
    .o_out_red   (o_out_red),
    .o_out_green (o_out_green),
    .o_out_blue  (o_out_blue),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
);

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import pbl_pkg::*;

    localparam int     RESET_CYCLES = 6;
    localparam int     PHASES       = 10;
    localparam int     PHASE_ITEMS  = 183;
    // margin to leave after the last owed color is back
    localparam int     IDLE_SLACK   = 8;
    localparam int     HOLD_CYCLES  = 80;
    localparam int     REPORT_LIMIT = 10;
    localparam longint TIMEOUT_NS   = 5_000_000;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    // one line of the directed table: an item, or a register write between items
    typedef struct {
        t_row_kind            kind;
        t_op                  op;
        logic [7:0]           idx;
        logic [PAL_IDX_W-1:0] slot;
        t_rgb                 color;
        bit                   typed;
        t_rgb                 known;
        logic                 cfg_reg;
        logic [7:0]           cfg_val;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_push;
    logic                  o_full;
    logic                  i_operation;
    logic [7:0]            i_color_index;
    logic [PAL_IDX_W-1:0]  i_entry_slot;
    logic [CHAN_W-1:0]     i_entry_red;
    logic [CHAN_W-1:0]     i_entry_green;
    logic [CHAN_W-1:0]     i_entry_blue;
    logic                  o_empty;
    logic                  i_pop;
    logic [CHAN_W-1:0]     o_out_red;
    logic [CHAN_W-1:0]     o_out_green;
    logic [CHAN_W-1:0]     o_out_blue;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    palette_blend_lookup dut (.*);

    // Shadow of the block: palette, which slots hold data, and both registers
    t_rgb       palette_shadow [PAL_DEPTH];
    bit         slot_loaded    [PAL_DEPTH];
    logic [7:0] bright_cfg;
    logic       blend_cfg;

    // colors still owed by the block, oldest first
    t_rgb       expected_colors [$];
    int         error_count;

    // sender burst bookkeeping and the receiver hold-off request
    int         burst_left;
    bit         hold_off_req;

    t_row       directed_rows [$];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or never drains
    initial begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Color predictor
    // ------------------------------------------------------------------

    function automatic logic [7:0] scale8(logic [7:0] a, logic [7:0] b);
        logic [15:0] prod;
        prod = a * b;
        return prod[15:8];
    endfunction

    // Brightness: full scale passes, zero blacks out, otherwise scale by
    // level+1 but leave black channels black.
    function automatic logic [7:0] dim_chan(logic [7:0] c);
        if (bright_cfg == FULL_SCALE)
            return c;
        if (bright_cfg == 8'd0 || c == 8'd0)
            return 8'd0;
        return scale8(c, bright_cfg + 8'd1);
    endfunction

    function automatic t_rgb predict_color(logic [7:0] idx);
        logic [PAL_IDX_W-1:0] hi;
        logic [PAL_IDX_W-1:0] lo;
        logic [PAL_IDX_W-1:0] nxt;
        logic [7:0]           w1;
        logic [7:0]           w2;
        t_rgb                 cur;
        t_rgb                 far;
        t_rgb                 mixed;
        hi    = idx[7:4];
        lo    = idx[3:0];
        cur   = palette_shadow[hi];
        mixed = cur;
        if (lo != '0 && blend_cfg) begin
            w2  = {lo, 4'h0};
            w1  = FULL_SCALE - w2;
            // 4-bit add wraps the last entry back to the first
            nxt = hi + 1'b1;
            far = palette_shadow[nxt];
            mixed.red   = scale8(cur.red,   w1) + scale8(far.red,   w2);
            mixed.green = scale8(cur.green, w1) + scale8(far.green, w2);
            mixed.blue  = scale8(cur.blue,  w1) + scale8(far.blue,  w2);
        end
        mixed.red   = dim_chan(mixed.red);
        mixed.green = dim_chan(mixed.green);
        mixed.blue  = dim_chan(mixed.blue);
        return mixed;
    endfunction

    // ------------------------------------------------------------------
    // Directed table rows
    // ------------------------------------------------------------------

    function automatic t_row write_row(logic [PAL_IDX_W-1:0] slot, t_rgb color,
                                       logic [7:0] junk_idx);
        t_row r;
        r.kind  = ROW_ITEM;
        r.op    = OP_WRITE;
        r.idx   = junk_idx;
        r.slot  = slot;
        r.color = color;
        r.typed = 1'b0;
        return r;
    endfunction

    // lookup checked by the predictor; the ignored fields carry noise
    function automatic t_row look_row(logic [7:0] idx);
        t_row r;
        r.kind  = ROW_ITEM;
        r.op    = OP_LOOKUP;
        r.idx   = idx;
        r.slot  = PAL_IDX_W'($urandom);
        r.color = 24'($urandom);
        r.typed = 1'b0;
        return r;
    endfunction

    // lookup whose answer is obvious; ignored fields set to all ones
    function automatic t_row known_row(logic [7:0] idx, t_rgb known);
        t_row r;
        r.kind  = ROW_ITEM;
        r.op    = OP_LOOKUP;
        r.idx   = idx;
        r.slot  = '1;
        r.color = '1;
        r.typed = 1'b1;
        r.known = known;
        return r;
    endfunction

    function automatic t_row cfg_row(logic reg_sel, logic [7:0] val);
        t_row r;
        r.kind    = ROW_CFG;
        r.typed   = 1'b0;
        r.cfg_reg = reg_sel;
        r.cfg_val = val;
        return r;
    endfunction

    // mostly random, with extra weight on black and full channels
    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one item and hold it until the transfer; then update the shadow
    // and queue the color it owes.
    task automatic push_item(t_op op, logic [7:0] idx, logic [PAL_IDX_W-1:0] slot,
                             t_rgb color, bit typed, t_rgb known);
        @(negedge i_clk);
        i_push        <= 1'b1;
        i_operation   <= op;
        i_color_index <= idx;
        i_entry_slot  <= slot;
        i_entry_red   <= color.red;
        i_entry_green <= color.green;
        i_entry_blue  <= color.blue;
        do begin
            @(posedge i_clk);
        end while (o_full);
        if (op == OP_WRITE) begin
            palette_shadow[slot] = color;
            slot_loaded[slot]    = 1'b1;
        end else begin
            expected_colors.push_back(typed ? known : predict_color(idx));
        end
    endtask

    // Bursts of random length; between bursts drop push for a random gap.
    // Now and then a long burst with no gap at all.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                burst_left = $urandom_range(40, 90);
                gap        = 0;
            end else begin
                burst_left = $urandom_range(1, 16);
                gap        = $urandom_range(1, 7);
            end
            repeat (gap) begin
                @(negedge i_clk);
                i_push <= 1'b0;
            end
        end
        burst_left--;
    endtask

    // Stop offering, wait for every owed color, then let the pipe run dry
    // (a trailing palette write leaves nothing to wait on).
    task automatic settle_block();
        @(negedge i_clk);
        i_push <= 1'b0;
        while (expected_colors.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_SLACK) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge that sees pready.
    task automatic write_reg(logic reg_sel, logic [7:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= CFG_DATA_W'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        if (reg_sel == REG_BRIGHTNESS)
            bright_cfg = val;
        else
            blend_cfg = val[0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall pattern, long hold-off on request, result check
    // ------------------------------------------------------------------
    initial begin
        int               hold_left;
        int               rx_cycle;
        int               stall_mode;
        logic [15:0]      stall_word;
        t_rgb             want;
        t_rgb             got;
        hold_left  = 0;
        rx_cycle   = 0;
        stall_mode = 0;
        stall_word = '1;
        i_pop      = 1'b0;
        do begin
            @(posedge i_clk);
        end while (i_rst_n !== 1'b1);
        forever begin
            @(negedge i_clk);
            // pick a new stall style
            if (rx_cycle % 128 == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_word = 16'($urandom);
            end
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                // hold off so the block backs up and raises full
                hold_left--;
                i_pop <= 1'b0;
            end else begin
                case (stall_mode)
                    0: i_pop <= 1'b1;
                    1: i_pop <= ($urandom_range(0, 2) != 0);
                    default: i_pop <= stall_word[rx_cycle % 16];
                endcase
            end
            rx_cycle++;

            @(posedge i_clk);
            if (i_pop && !o_empty) begin
                got = {o_out_red, o_out_green, o_out_blue};
                if (expected_colors.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: unexpected color r=%h g=%h b=%h", $time,
                                 got.red, got.green, got.blue);
                end else begin
                    want = expected_colors.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("%0t: mismatch, expected %h %h %h, got %h %h %h",
                                     $time, want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [7:0]           br;
        logic                 bl;
        logic [PAL_IDX_W-1:0] hi;
        t_rgb                 color;

        i_rst_n       = 1'b0;
        i_push        = 1'b0;
        i_operation   = OP_LOOKUP;
        i_color_index = '0;
        i_entry_slot  = '0;
        i_entry_red   = '0;
        i_entry_green = '0;
        i_entry_blue  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        bright_cfg    = BRIGHTNESS_RESET;
        blend_cfg     = BLEND_RESET;
        error_count   = 0;
        burst_left    = 0;
        hold_off_req  = 1'b0;
        foreach (slot_loaded[s]) begin
            slot_loaded[s]    = 1'b0;
            palette_shadow[s] = '0;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Load the slots first so no lookup ever touches an empty one
        // (including the neighbor a blend would read).
        directed_rows = '{
            write_row(4'h0, 24'hFFFFFF, 8'h00),
            write_row(4'h1, 24'h000000, 8'hFF),
            write_row(4'h2, 24'h8001FE, 8'hFF),
            write_row(4'hF, 24'hA55A3C, 8'h5A),
            write_row(4'h3, 24'h00FF00, 8'h3C),
            // reset settings: full brightness, blending on
            known_row(8'h00, 24'hFFFFFF),
            known_row(8'h10, 24'h000000),
            known_row(8'h20, 24'h8001FE),
            look_row(8'h08),
            look_row(8'h0F),
            look_row(8'h1F),
            // blend across the wrap from the last slot to the first
            look_row(8'hF8),
            look_row(8'hFF),
            // brightness zero blacks everything out
            cfg_row(REG_BRIGHTNESS, 8'h00),
            known_row(8'h00, 24'h000000),
            known_row(8'hF8, 24'h000000),
            cfg_row(REG_BRIGHTNESS, 8'h01),
            look_row(8'h20),
            cfg_row(REG_BRIGHTNESS, 8'hFE),
            look_row(8'h00),
            known_row(8'h10, 24'h000000),
            // blending off: the fraction is ignored
            cfg_row(REG_BLEND, 8'h00),
            look_row(8'h0F),
            cfg_row(REG_BRIGHTNESS, FULL_SCALE),
            known_row(8'hF8, 24'hA55A3C),
            cfg_row(REG_BLEND, 8'h01)
        };

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_CFG) begin
                settle_block();
                write_reg(directed_rows[k].cfg_reg, directed_rows[k].cfg_val);
            end else begin
                pace_sender();
                push_item(directed_rows[k].op, directed_rows[k].idx,
                          directed_rows[k].slot, directed_rows[k].color,
                          directed_rows[k].typed, directed_rows[k].known);
            end
        end

        // Random phases, each under its own register settings
        for (int phase = 0; phase < PHASES; phase++) begin
            settle_block();
            case (phase)
                0: begin br = FULL_SCALE; bl = 1'b1; end
                1: begin br = 8'h00;      bl = 1'b1; end
                2: begin br = 8'h01;      bl = 1'b0; end
                3: begin br = 8'hFE;      bl = 1'b1; end
                4: begin br = FULL_SCALE; bl = 1'b0; end
                default: begin
                    br = 8'($urandom);
                    bl = 1'($urandom);
                end
            endcase
            // ask for the long receiver hold-off while the sender keeps going
            if (phase == 2)
                hold_off_req = 1'b1;
            write_reg(REG_BRIGHTNESS, br);
            write_reg(REG_BLEND, bl);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // once, pause the sender until every owed color is back
                if (phase == 6 && n == PHASE_ITEMS / 2)
                    settle_block();
                pace_sender();
                if ($urandom_range(0, 9) < 3) begin
                    color = {rand_chan(), rand_chan(), rand_chan()};
                    push_item(OP_WRITE, 8'($urandom), PAL_IDX_W'($urandom), color,
                              1'b0, '0);
                end else begin
                    // only look up where this slot and its neighbor hold data
                    do begin
                        hi = PAL_IDX_W'($urandom);
                    end while (!(slot_loaded[hi] && slot_loaded[hi + 1'b1]));
                    push_item(OP_LOOKUP, {hi, 4'($urandom)}, PAL_IDX_W'($urandom),
                              24'($urandom), 1'b0, '0);
                end
            end
        end

        settle_block();
        if (error_count == 0 && expected_colors.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* palette_blend_lookup.f */
src/pbl_pkg.sv
src/pbl_queue.sv
src/pbl_front.sv
src/pbl_back.sv
src/palette_blend_lookup.sv
src/pbl_checker.sv
bench/testbench.sv
